### sv/qps_pkg.sv
// ============================================================================
// qps_pkg
// Shared widths, codes, constants and helper functions for the quadrature
// position servo.
// ============================================================================
package qps_pkg;

    // Field widths
    localparam int TARGET_W   = 18;
    localparam int DEADBAND_W = 15;
    localparam int GAIN_W     = 12;
    localparam int SCALE_W    = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int WIDTH_W    = 26;
    localparam int DEG_OUT_W  = 26;
    localparam int COUNT_W    = 32;

    // Datapath widths
    localparam int DRIVE_W    = 13;   // drive in Q8, +-12.0 fits
    localparam int ACC_W      = 42;   // Horner accumulator, Q24
    localparam int STEP_W     = 3;

    // Input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE    = 2'd3;

    // Register reset values
    localparam logic signed [TARGET_W-1:0] TARGET_RESET   = 18'sd11520;
    localparam logic [DEADBAND_W-1:0]      DEADBAND_RESET = 15'd1280;
    localparam logic [GAIN_W-1:0]          GAIN_RESET     = 12'd500;
    localparam logic [SCALE_W-1:0]         SCALE_RESET    = 16'd2069;

    // Drive limit of +-12.0 in Q8 and pulse width constants
    localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT  = 13'sd3072;
    localparam logic [9:0]                WIDTH_STEP   = 10'd650;
    localparam logic [WIDTH_W-1:0]        IDLE_WIDTH   = 26'd1;
    localparam logic [WIDTH_W-1:0]        WIDTH_MAX    = 26'h3FFFFFF;

    // Shown position limits
    localparam logic signed [32:0] DEG_MAX = 33'sd33554431;
    localparam logic signed [32:0] DEG_MIN = -33'sd33554432;

    // Horner schedule: six steps, the last one adds nothing
    localparam logic [STEP_W-1:0] HORNER_LAST = 3'd5;

    // Leading polynomial coefficient, Q24
    localparam logic signed [ACC_W-1:0] COEF_C6 = 42'sd32942;

    // Command bundle from the controller to the datapath
    typedef struct packed {
        logic              enc_update;
        logic              scale;
        logic              err_calc;
        logic              drive;
        logic              horner;
        logic [STEP_W-1:0] step;
        logic              load_result;
    } cmd_t;

    // Coefficient added at each Horner step, Q24
    function automatic logic signed [ACC_W-1:0] horner_coef(input logic [STEP_W-1:0] step);
        logic signed [ACC_W-1:0] c;
        unique case (step)
            3'd0:    c = -42'sd1168270;
            3'd1:    c = 42'sd16223102;
            3'd2:    c = -42'sd107869606;
            3'd3:    c = 42'sd334402407;
            3'd4:    c = -42'sd342001444;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Forward successor in Gray order 00 -> 10 -> 11 -> 01 -> 00
    function automatic logic [1:0] quad_fwd(input logic [1:0] prev);
        logic [1:0] n;
        unique case (prev)
            2'd0:    n = 2'd2;
            2'd1:    n = 2'd0;
            2'd2:    n = 2'd3;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

    // Reverse successor
    function automatic logic [1:0] quad_rev(input logic [1:0] prev);
        logic [1:0] n;
        unique case (prev)
            2'd0:    n = 2'd1;
            2'd1:    n = 2'd3;
            2'd2:    n = 2'd0;
            default: n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

### sv/qps_sample_if.sv
// ============================================================================
// qps_sample_if
// Input channel: encoder samples and control ticks with valid/ready.
// ============================================================================
interface qps_sample_if;
    logic valid;
    logic ready;
    logic op;
    logic chan_a_level;
    logic chan_b_level;

    modport source (output valid, output op, output chan_a_level, output chan_b_level,
                    input ready);
    modport sink   (input valid, input op, input chan_a_level, input chan_b_level,
                    output ready);
endinterface

### sv/qps_result_if.sv
// ============================================================================
// qps_result_if
// Output channel: pulse widths, settled flag and shown position.
// ============================================================================
interface qps_result_if
    import qps_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [WIDTH_W-1:0]          forward_width;
    logic [WIDTH_W-1:0]          reverse_width;
    logic                        settled;
    logic signed [DEG_OUT_W-1:0] position_deg;

    modport source (output valid, output forward_width, output reverse_width,
                    output settled, output position_deg, input ready);
    modport sink   (input valid, input forward_width, input reverse_width,
                    input settled, input position_deg, output ready);
endinterface

### sv/qps_cfg_if.sv
// ============================================================================
// qps_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface qps_cfg_if
    import qps_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/qps_controller.sv
// ============================================================================
// qps_controller
// Sequencer for the servo: accepts items, steps a control tick through
// scaling, error, drive, Horner steps and shaping, and owns result valid.
// ============================================================================
module qps_controller
    import qps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic sample_valid,
    input  logic sample_op,
    output logic sample_ready,
    output logic result_valid,
    input  logic result_ready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_ERROR,
        S_DRIVE,
        S_HORNER,
        S_SHAPE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              result_valid_reg, result_valid_next;
    logic              sample_fire;

    assign sample_ready = (state_reg == S_IDLE);
    assign sample_fire  = sample_valid && sample_ready;
    assign result_valid = result_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd               = '0;
        cmd.step          = step_reg;
        state_next        = state_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;

        // Drop result valid once the transaction completes
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_fire)
                begin
                    if (sample_op == OP_TICK)
                    begin
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        cmd.enc_update = 1'b1;
                    end
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_ERROR;
            end
            S_ERROR:
            begin
                cmd.err_calc = 1'b1;
                state_next   = S_DRIVE;
            end
            S_DRIVE:
            begin
                cmd.drive  = 1'b1;
                step_next  = '0;
                state_next = S_HORNER;
            end
            S_HORNER:
            begin
                cmd.horner = 1'b1;
                step_next  = step_reg + 3'd1;
                if (step_reg == HORNER_LAST)
                begin
                    state_next = S_SHAPE;
                end
            end
            S_SHAPE:
            begin
                // Hold until the result register is free
                if (!result_valid_reg || result_ready)
                begin
                    cmd.load_result   = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

### sv/qps_datapath.sv
// ============================================================================
// qps_datapath
// Configuration registers, quadrature counter, degree scaling, error and
// drive stages, shared Horner multiplier and the result register.
// ============================================================================
module qps_datapath
    import qps_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    input  logic                        chan_a_level,
    input  logic                        chan_b_level,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output logic [WIDTH_W-1:0]          forward_width,
    output logic [WIDTH_W-1:0]          reverse_width,
    output logic                        settled,
    output logic signed [DEG_OUT_W-1:0] position_deg
);

    // Configuration registers
    logic signed [TARGET_W-1:0] target_reg;
    logic [DEADBAND_W-1:0]      deadband_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [SCALE_W-1:0]         scale_reg;

    // Encoder state
    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic                      last_a_reg, last_b_reg;
    logic [1:0]                prev_levels, now_levels;

    // Tick pipeline registers
    logic signed [48:0]          scale_prod_reg, scale_prod_next;
    logic signed [32:0]          deg;
    logic signed [ACC_W-1:0]     err, db_pos, db_neg, err_lim;
    logic signed [DRIVE_W-1:0]   err_clamp;
    logic signed [DEG_OUT_W-1:0] shown;
    logic                        active;
    logic                        active_reg;
    logic signed [DRIVE_W-1:0]   err_clamp_reg;
    logic signed [DEG_OUT_W-1:0] shown_reg;

    logic signed [25:0]          drive_prod;
    logic signed [DRIVE_W-1:0]   drive;
    logic signed [DRIVE_W-1:0]   x_reg;
    logic                        drive_neg_reg;

    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [54:0]          horner_prod;
    logic signed [46:0]          horner_quot;

    logic signed [17:0]          poly;
    logic signed [17:0]          reduced;
    logic [26:0]                 width_prod;
    logic [WIDTH_W-1:0]          width;

    // Result register
    logic [WIDTH_W-1:0]          forward_reg, reverse_reg;
    logic                        settled_reg;
    logic signed [DEG_OUT_W-1:0] position_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RESET;
            deadband_reg <= DEADBAND_RESET;
            gain_reg     <= GAIN_RESET;
            scale_reg    <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET:   target_reg   <= $signed(cfg_data[TARGET_W-1:0]);
                REG_DEADBAND: deadband_reg <= cfg_data[DEADBAND_W-1:0];
                REG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                default:      target_reg   <= target_reg;
            endcase
        end
    end

    // Advance the position count through the quadrature table
    assign prev_levels = {last_a_reg, last_b_reg};
    assign now_levels  = {chan_a_level, chan_b_level};

    always_comb
    begin
        priority if (now_levels == quad_fwd(prev_levels))
        begin
            count_next = count_reg + 32'sd1;
        end
        else if (now_levels == quad_rev(prev_levels))
        begin
            count_next = count_reg - 32'sd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
        end
        else if (cmd.enc_update)
        begin
            count_reg  <= count_next;
            last_a_reg <= chan_a_level;
            last_b_reg <= chan_b_level;
        end
    end

    // Scale counts to degrees in Q16
    assign scale_prod_next = count_reg * $signed({1'b0, scale_reg});

    // Degrees truncated toward zero, error in Q8, deadband test and clamps
    always_comb
    begin
        deg = $signed(scale_prod_reg[48:16]);
        if (scale_prod_reg[48] && (scale_prod_reg[15:0] != '0))
        begin
            deg = deg + 33'sd1;
        end

        err    = $signed({{(ACC_W - TARGET_W){target_reg[TARGET_W-1]}}, target_reg})
               - $signed({deg[32], deg, 8'd0});
        db_pos = $signed({{(ACC_W - DEADBAND_W){1'b0}}, deadband_reg});
        db_neg = -db_pos;
        active = (err > db_pos) || (err < db_neg);

        // Clamp one above the drive limit so any nonzero gain still saturates
        err_lim = $signed({{(ACC_W - DRIVE_W){1'b0}}, DRIVE_LIMIT}) + 42'sd1;
        priority if (err > err_lim)
        begin
            err_clamp = DRIVE_LIMIT + 13'sd1;
        end
        else if (err < -err_lim)
        begin
            err_clamp = -(DRIVE_LIMIT + 13'sd1);
        end
        else
        begin
            err_clamp = err[DRIVE_W-1:0];
        end

        priority if (deg > DEG_MAX)
        begin
            shown = DEG_MAX[DEG_OUT_W-1:0];
        end
        else if (deg < DEG_MIN)
        begin
            shown = DEG_MIN[DEG_OUT_W-1:0];
        end
        else
        begin
            shown = deg[DEG_OUT_W-1:0];
        end
    end

    // Drive: gain times error, clamped to +-12.0
    assign drive_prod = $signed({1'b0, gain_reg}) * err_clamp_reg;

    always_comb
    begin
        priority if (drive_prod > $signed({{13{1'b0}}, DRIVE_LIMIT}))
        begin
            drive = DRIVE_LIMIT;
        end
        else if (drive_prod < -$signed({{13{1'b0}}, DRIVE_LIMIT}))
        begin
            drive = -DRIVE_LIMIT;
        end
        else
        begin
            drive = drive_prod[DRIVE_W-1:0];
        end
    end

    // One Horner step: coefficient plus acc times x over 256, toward zero
    always_comb
    begin
        horner_prod = acc_reg * x_reg;
        horner_quot = $signed(horner_prod[54:8]);
        if (horner_prod[54] && (horner_prod[7:0] != '0))
        begin
            horner_quot = horner_quot + 47'sd1;
        end
        acc_next = horner_quot[ACC_W-1:0] + horner_coef(cmd.step);
    end

    // Shape the polynomial value into a pulse width
    always_comb
    begin
        poly = $signed(acc_reg[ACC_W-1:24]);
        if (acc_reg[ACC_W-1] && (acc_reg[23:0] != '0))
        begin
            poly = poly + 18'sd1;
        end

        if (poly > 18'sd2)
        begin
            reduced = poly - 18'sd2;
        end
        else
        begin
            reduced = poly;
        end

        if (reduced > 18'sd0)
        begin
            width_prod = {10'd0, reduced[16:0]} * {17'd0, WIDTH_STEP};
        end
        else
        begin
            width_prod = '0;
        end

        if (width_prod > {1'b0, WIDTH_MAX})
        begin
            width = WIDTH_MAX;
        end
        else
        begin
            width = width_prod[WIDTH_W-1:0];
        end
    end

    // Tick pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            scale_prod_reg <= scale_prod_next;
        end
        if (cmd.err_calc)
        begin
            active_reg    <= active;
            err_clamp_reg <= err_clamp;
            shown_reg     <= shown;
        end
        if (cmd.drive)
        begin
            x_reg         <= drive;
            drive_neg_reg <= drive_prod < 26'sd0;
            acc_reg       <= COEF_C6;
        end
        else if (cmd.horner)
        begin
            acc_reg <= acc_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            forward_reg  <= (active_reg && !drive_neg_reg) ? width : IDLE_WIDTH;
            reverse_reg  <= (active_reg && drive_neg_reg) ? width : IDLE_WIDTH;
            settled_reg  <= !active_reg;
            position_reg <= shown_reg;
        end
    end

    assign forward_width = forward_reg;
    assign reverse_width = reverse_reg;
    assign settled       = settled_reg;
    assign position_deg  = position_reg;

endmodule

### sv/quadrature_position_servo.sv
// ============================================================================
// quadrature_position_servo
// Proportional position servo with deadband, fed by a quadrature encoder.
// ============================================================================
// An encoder sample gives no result. A control tick goes from acceptance to
// loading its result through an accepting step, degree scaling, error and
// drive, six Horner steps through the single 42 x 13 bit polynomial
// multiplier, and one step to shape the pulse width.
// No new item is taken while a tick is in progress. The result sits in an
// output register, so samples and the next tick are taken while it waits;
// a finished tick holds in its last step only if the previous result has not
// yet been taken. The configuration port is always ready and should be
// written only while the block is idle.
// ============================================================================
module quadrature_position_servo
    import qps_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    qps_sample_if.sink    sample,
    qps_result_if.source  result,
    qps_cfg_if.sink       cfg
);

    cmd_t cmd;
    logic cfg_we;

    // Accept configuration transactions at once
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    qps_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_op    (sample.op),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    qps_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .chan_a_level  (sample.chan_a_level),
        .chan_b_level  (sample.chan_b_level),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .forward_width (result.forward_width),
        .reverse_width (result.reverse_width),
        .settled       (result.settled),
        .position_deg  (result.position_deg)
    );

endmodule

### tb/quadrature_position_servo_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature position servo testbench
// Drives encoder samples and control ticks through the sample channel,
// rewrites the four servo registers between phases while the block is idle
// and checks every result transaction against a cycle-free model of the
// position count, the degree conversion, the deadband and the polynomial
// pulse width shaping. Both channels idle at random, and the result side
// holds off once for a long stretch so that the block back-pressures.
// ----------------------------------------------------------------------------
module quadrature_position_servo_test;
    import qps_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int TAIL_CYCLES = 16;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 45;

    // Q24 shaping polynomial, leading term first
    localparam longint SHAPE_LEAD = 32942;
    localparam longint SHAPE_K [5] = '{-1168270, 16223102, -107869606, 334402407,
                                       -342001444};
    localparam longint DRIVE_CLAMP = 3072;
    localparam longint PULSE_STEP  = 650;
    localparam longint PULSE_MAX   = 67108863;
    localparam longint SHOWN_MAX   = 33554431;
    localparam longint SHOWN_MIN   = -33554432;

    typedef struct packed {
        logic [WIDTH_W-1:0]          forward_width;
        logic [WIDTH_W-1:0]          reverse_width;
        logic                        settled;
        logic signed [DEG_OUT_W-1:0] position_deg;
    } servo_result_t;

    // Place of a pin pair in the forward Gray order 00 -> 10 -> 11 -> 01
    function automatic int gray_pos(input logic [1:0] ab);
        int p;
        case (ab)
            2'b00:   p = 0;
            2'b10:   p = 1;
            2'b11:   p = 2;
            default: p = 3;
        endcase
        return p;
    endfunction

    class servo_scoreboard;
        logic signed [TARGET_W-1:0] target;
        logic [DEADBAND_W-1:0]      deadband;
        logic [GAIN_W-1:0]          gain;
        logic [SCALE_W-1:0]         scale;
        logic [COUNT_W-1:0]         count;
        logic [1:0]                 last_ab;
        servo_result_t              drive_outputs_due [$];
        int                         errors;

        function new();
            target   = TARGET_RESET;
            deadband = DEADBAND_RESET;
            gain     = GAIN_RESET;
            scale    = SCALE_RESET;
            count    = '0;
            last_ab  = 2'b00;
            errors   = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET:   target   = data[TARGET_W-1:0];
                REG_DEADBAND: deadband = data[DEADBAND_W-1:0];
                REG_GAIN:     gain     = data[GAIN_W-1:0];
                default:      scale    = data[SCALE_W-1:0];
            endcase
        endfunction

        function longint shape_width(input longint x);
            longint acc;
            longint p;
            longint w;
            acc = SHAPE_LEAD;
            for (int i = 0; i < 5; i++)
                acc = SHAPE_K[3'(i)] + (acc * x) / 256;
            acc = (acc * x) / 256;
            p = acc / 16777216;
            w = (p > 2) ? (p - 2) * PULSE_STEP : p * PULSE_STEP;
            if (w < 0)
                w = 0;
            if (w > PULSE_MAX)
                w = PULSE_MAX;
            return w;
        endfunction

        function servo_result_t tick_response();
            servo_result_t r;
            longint cnt;
            longint deg;
            longint err;
            longint band;
            longint drive;
            longint shown;
            longint w;
            cnt   = longint'($signed(count));
            deg   = (cnt * longint'(scale)) / 65536;
            err   = longint'(target) - deg * 256;
            band  = longint'(deadband);
            shown = deg;
            if (shown > SHOWN_MAX)
                shown = SHOWN_MAX;
            if (shown < SHOWN_MIN)
                shown = SHOWN_MIN;
            r.position_deg  = shown[DEG_OUT_W-1:0];
            r.forward_width = IDLE_WIDTH;
            r.reverse_width = IDLE_WIDTH;
            r.settled       = 1'b0;
            if (err > band || err < -band)
            begin
                drive = longint'(gain) * err;
                if (drive < 0)
                begin
                    if (drive < -DRIVE_CLAMP)
                        drive = -DRIVE_CLAMP;
                    w = shape_width(drive);
                    r.reverse_width = w[WIDTH_W-1:0];
                end
                else
                begin
                    if (drive > DRIVE_CLAMP)
                        drive = DRIVE_CLAMP;
                    w = shape_width(drive);
                    r.forward_width = w[WIDTH_W-1:0];
                end
            end
            else
                r.settled = 1'b1;
            return r;
        endfunction

        // Advance the count on a sample, queue the expected outputs on a tick
        function void note_item(input logic op, input logic a, input logic b);
            int stride;
            if (op == OP_SAMPLE)
            begin
                stride = (gray_pos({a, b}) - gray_pos(last_ab)) & 3;
                if (stride == 1)
                    count = count + 1;
                else if (stride == 3)
                    count = count - 1;
                last_ab = {a, b};
            end
            else
                drive_outputs_due.push_back(tick_response());
        endfunction

        function void check_result(input servo_result_t got);
            servo_result_t exp_r;
            if (drive_outputs_due.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: fwd %0d rev %0d st %0d pos %0d",
                         $time, got.forward_width, got.reverse_width, got.settled,
                         got.position_deg);
                errors++;
                return;
            end
            exp_r = drive_outputs_due.pop_front();
            if (got.forward_width !== exp_r.forward_width)
            begin
                $display("%0t: forward_width expected %0d got %0d",
                         $time, exp_r.forward_width, got.forward_width);
                errors++;
            end
            if (got.reverse_width !== exp_r.reverse_width)
            begin
                $display("%0t: reverse_width expected %0d got %0d",
                         $time, exp_r.reverse_width, got.reverse_width);
                errors++;
            end
            if (got.settled !== exp_r.settled)
            begin
                $display("%0t: settled expected %0d got %0d",
                         $time, exp_r.settled, got.settled);
                errors++;
            end
            if (got.position_deg !== exp_r.position_deg)
            begin
                $display("%0t: position_deg expected %0d got %0d",
                         $time, exp_r.position_deg, got.position_deg);
                errors++;
            end
        endfunction

        function int outstanding();
            return drive_outputs_due.size();
        endfunction

        function void report_leftover();
            if (drive_outputs_due.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived",
                         $time, drive_outputs_due.size());
                errors += drive_outputs_due.size();
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qps_sample_if smp();
    qps_result_if res();
    qps_cfg_if    cfg();

    servo_scoreboard sb = new();

    bit steady;
    bit long_hold_req;
    int walk_idx;

    quadrature_position_servo DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(smp),
        .result(res),
        .cfg   (cfg)
    );

    // Clock
    always #HALF_PERIOD clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Observe every transaction on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                sb.set_reg(cfg.index, cfg.data);
            if (smp.valid && smp.ready)
                sb.note_item(smp.op, smp.chan_a_level, smp.chan_b_level);
            if (res.valid && res.ready)
                sb.check_result('{res.forward_width, res.reverse_width, res.settled,
                                  res.position_deg});
        end
    end

    // Result side: random runs and stalls, with one long hold on request
    initial
    begin
        int run_left;
        int stall_left;
        int hold_left;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                res.ready <= 1'b1;
            end
            else
            begin
                run_left   = $urandom_range(1, 12);
                stall_left = pick_gap();
                res.ready <= 1'b1;
            end
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic op, input logic a, input logic b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid        <= 1'b1;
        smp.op           <= op;
        smp.chan_a_level <= a;
        smp.chan_b_level <= b;
        do
            @(posedge clk);
        while (smp.ready !== 1'b1);
    endtask

    task automatic send_sample(input logic a, input logic b);
        send_item(OP_SAMPLE, a, b);
        walk_idx = gray_pos({a, b});
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 1'($urandom), 1'($urandom));
    endtask

    // Drop valid, wait for every result, then let the datapath go quiet
    task automatic wait_drained();
        smp.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Valid stays high between back-to-back register writes
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
    endtask

    // Unused upper data bits carry noise, the block must drop them
    task automatic write_settings(input int tgt, input int band, input int kp,
                                  input int deg_scale);
        write_reg(REG_TARGET, tgt[TARGET_W-1:0]);
        write_reg(REG_DEADBAND, {3'($urandom), band[DEADBAND_W-1:0]});
        write_reg(REG_GAIN, {6'($urandom), kp[GAIN_W-1:0]});
        write_reg(REG_SCALE, {2'($urandom), deg_scale[SCALE_W-1:0]});
        cfg.valid <= 1'b0;
    endtask

    task automatic random_settings();
        int r;
        int tgt;
        int band;
        int kp;
        int deg_scale;
        r = $urandom_range(0, 99);
        if (r < 10)
            tgt = 92160;
        else if (r < 20)
            tgt = -92160;
        else if (r < 60)
            tgt = int'($urandom_range(0, 60000)) - 30000;
        else
            tgt = int'($urandom_range(0, 184320)) - 92160;
        r = $urandom_range(0, 99);
        if (r < 25)
            band = 0;
        else if (r < 35)
            band = 23040;
        else
            band = $urandom_range(0, 3000);
        r = $urandom_range(0, 99);
        if (r < 15)
            kp = 0;
        else if (r < 30)
            kp = 4095;
        else if (r < 60)
            kp = $urandom_range(1, 8);
        else
            kp = $urandom_range(0, 4095);
        r = $urandom_range(0, 99);
        if (r < 15)
            deg_scale = 0;
        else if (r < 30)
            deg_scale = 65535;
        else if (r < 70)
            deg_scale = $urandom_range(32768, 65535);
        else
            deg_scale = $urandom_range(0, 65535);
        write_settings(tgt, band, kp, deg_scale);
    endtask

    // Mostly clean quadrature steps with ticks mixed in, plus some pin noise
    task automatic run_phase(input int n_items, input int tick_pct, input int fwd_pct);
        logic [1:0] gray_seq [4];
        logic [1:0] ab;
        int r;
        gray_seq = '{2'b00, 2'b10, 2'b11, 2'b01};
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                send_tick();
            else if (r < tick_pct + 8)
            begin
                ab = 2'($urandom);
                send_sample(ab[1], ab[0]);
            end
            else
            begin
                if ($urandom_range(0, 99) < fwd_pct)
                    ab = gray_seq[2'(walk_idx + 1)];
                else
                    ab = gray_seq[2'(walk_idx + 3)];
                send_sample(ab[1], ab[0]);
            end
        end
    endtask

    // Stimulus
    initial
    begin
        smp.valid        <= 1'b0;
        smp.op           <= OP_SAMPLE;
        smp.chan_a_level <= 1'b0;
        smp.chan_b_level <= 1'b0;
        cfg.valid        <= 1'b0;
        cfg.index        <= REG_TARGET;
        cfg.data         <= '0;
        steady        = 1'b0;
        long_hold_req = 1'b0;
        walk_idx      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: forward steps, an unchanged pair, a diagonal jump,
        // one reverse step
        send_tick();
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_tick();
        wait_drained();

        // Most negative target at full gain: reverse drive, count goes negative
        write_settings(-92160, 0, 4095, 65535);
        send_tick();
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_tick();
        wait_drained();

        // Widest deadband with zero scale: settled
        write_settings(0, 23040, 0, 0);
        send_tick();
        wait_drained();

        // Zero gain outside the band: forward with a zero drive
        write_settings(92160, 0, 0, 65535);
        send_tick();
        wait_drained();

        // Unit gain: small drives either side of zero
        write_settings(100, 0, 1, 65535);
        send_tick();
        send_sample(1'b1, 1'b0);
        send_tick();
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        send_tick();
        wait_drained();

        // Largest target beyond the widest band
        write_settings(92160, 23040, 4095, 0);
        send_tick();
        wait_drained();

        // Random phases, one with no idling and one under a long result hold
        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_settings();
            steady = (ph == 3);
            if (ph == 6)
            begin
                long_hold_req = 1'b1;
                run_phase(PHASE_ITEMS, 60, 50);
            end
            else
                run_phase(PHASE_ITEMS, 20, $urandom_range(20, 80));
            wait_drained();
            steady = 1'b0;
        end

        sb.report_leftover();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
